### hw/rtl/emal_pkg.sv
// Shared types and constants for the extent map with append and lookup.
package emal_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W  = 32;
    localparam int LIMIT_W = 9;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;

    // Default table depth and the reset value of the fragment limit.
    localparam int                 MAX_ENTRIES_DEF = 256;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 9'd256;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIN1,
        S_FIN2,
        S_FIN3
    } t_state;

    // Lookup token handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              cov;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] phys;
        logic [DATA_W-1:0] len;
    } t_tok;

    // Table write from the controller to the cells.
    typedef struct packed {
        logic              we_new;
        logic              we_len;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] phys;
        logic [DATA_W-1:0] len;
    } t_wr;

endpackage

### hw/rtl/emal_cell.sv
// One table entry of the extent chain, with its stage of the lookup token.
module emal_cell #(
    parameter int IDX = 0,
    parameter int IW  = 8,
    parameter int UW  = 9
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  emal_pkg::t_wr              i_wr,
    input  logic [IW-1:0]              i_wr_idx,
    input  logic [emal_pkg::DATA_W-1:0] i_off,
    input  logic [emal_pkg::DATA_W-1:0] i_offend,
    input  emal_pkg::t_tok             i_tok,
    input  logic [UW-1:0]              i_left,
    output emal_pkg::t_tok             o_tok,
    output logic [UW-1:0]              o_left
);
    import emal_pkg::*;

    logic [DATA_W-1:0] r_lo;
    logic [DATA_W-1:0] r_phys;
    logic [DATA_W-1:0] r_len;
    t_tok              r_tok;
    t_tok              n_tok;
    logic [UW-1:0]     r_left;
    logic [UW-1:0]     n_left;
    logic              sel;
    logic [DATA_W-1:0] lend;
    logic              cov;
    logic              starts;
    logic              active;

    // Entry storage, written only when the controller addresses this cell.
    assign sel = (i_wr_idx == IW'(IDX));

    always_ff @(posedge i_clk) begin
        if (sel && i_wr.we_new) begin
            r_lo   <= i_wr.lo;
            r_phys <= i_wr.phys;
            r_len  <= i_wr.len;
        end else if (sel && i_wr.we_len) begin
            r_len  <= i_wr.len;
        end
    end

    // Match tests: the entry covers the offset, or starts inside the request.
    assign lend   = r_lo + r_len;
    assign cov    = (r_lo <= i_off) && (lend > i_off);
    assign starts = (r_lo > i_off) && (r_lo < i_offend);
    assign active = i_tok.valid && (i_left != '0) && !i_tok.hit;

    always_comb begin
        n_tok  = i_tok;
        n_left = (i_left != '0) ? i_left - UW'(1) : i_left;
        if (active && (cov || starts)) begin
            n_tok.hit  = 1'b1;
            n_tok.cov  = cov;
            n_tok.lo   = r_lo;
            n_tok.phys = r_phys;
            n_tok.len  = r_len;
        end
    end

    // Token stage towards the next cell; only the valid and hit flags are reset.
    always_ff @(posedge i_clk) begin
        r_tok.cov  <= n_tok.cov;
        r_tok.lo   <= n_tok.lo;
        r_tok.phys <= n_tok.phys;
        r_tok.len  <= n_tok.len;
        r_left     <= n_left;
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_tok.hit   <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
            r_tok.hit   <= n_tok.hit;
        end
    end

    assign o_tok  = r_tok;
    assign o_left = r_left;

endmodule

### hw/rtl/emal_ctrl.sv
// Controller: command handshake, append and clear, lookup injection and result.
module emal_ctrl #(
    parameter int MAX_ENTRIES = emal_pkg::MAX_ENTRIES_DEF,
    parameter int IW          = 8,
    parameter int UW          = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [emal_pkg::KIND_W-1:0]  i_kind,
    input  logic [emal_pkg::DATA_W-1:0]  i_logical_offset,
    input  logic [emal_pkg::DATA_W-1:0]  i_physical_sector,
    input  logic [emal_pkg::DATA_W-1:0]  i_block_count,
    input  logic                         i_cfg_we,
    input  logic [emal_pkg::LIMIT_W-1:0] i_cfg_wdata,
    output emal_pkg::t_wr                o_wr,
    output logic [IW-1:0]                o_wr_idx,
    output logic [emal_pkg::DATA_W-1:0]  o_off,
    output logic [emal_pkg::DATA_W-1:0]  o_offend,
    output emal_pkg::t_tok               o_tok,
    output logic [UW-1:0]                o_left,
    input  emal_pkg::t_tok               i_tail,
    output logic                         o_done,
    output logic [emal_pkg::STAT_W-1:0]  o_status,
    output logic [emal_pkg::DATA_W-1:0]  o_found_offset,
    output logic [emal_pkg::DATA_W-1:0]  o_found_sector,
    output logic [emal_pkg::DATA_W-1:0]  o_found_count,
    output logic [emal_pkg::LIMIT_W-1:0] o_entries_used,
    output logic [emal_pkg::DATA_W-1:0]  o_mapped_size
);
    import emal_pkg::*;

    localparam logic [DATA_W-1:0] MAX_W = DATA_W'(MAX_ENTRIES);

    t_state            r_state, n_state;
    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic [UW-1:0]     r_used, n_used;
    logic [DATA_W-1:0] r_total, n_total;
    logic [DATA_W-1:0] r_last_lend, n_last_lend;
    logic [DATA_W-1:0] r_last_pend, n_last_pend;
    logic [DATA_W-1:0] r_last_len, n_last_len;
    logic [DATA_W-1:0] r_off, n_off;
    logic [DATA_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0] r_offend, n_offend;
    logic              r_inject, n_inject;
    logic              r_hit, n_hit;
    logic              r_cov, n_cov;
    logic [DATA_W-1:0] r_lo, n_lo;
    logic [DATA_W-1:0] r_phys, n_phys;
    logic [DATA_W-1:0] r_len, n_len;
    logic [DATA_W-1:0] r_delta, n_delta;
    logic [DATA_W-1:0] r_run, n_run;
    logic              r_done, n_done;
    logic [STAT_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_fo, n_fo;
    logic [DATA_W-1:0] r_fs, n_fs;
    logic [DATA_W-1:0] r_fc, n_fc;
    logic [DATA_W-1:0] eff_limit;
    logic              accept;
    logic              merge;
    logic              full;
    logic [DATA_W-1:0] new_end;

    assign accept    = start && !busy;
    assign eff_limit = (DATA_W'(r_limit) > MAX_W) ? MAX_W : DATA_W'(r_limit);
    assign merge     = (r_used != '0) && (r_last_lend == i_logical_offset)
                       && (r_last_pend == i_physical_sector);
    assign full      = (DATA_W'(r_used) >= eff_limit);
    assign new_end   = i_logical_offset + i_block_count;

    // Next state, table writes and result values.
    always_comb begin
        n_state     = r_state;
        n_limit     = i_cfg_we ? i_cfg_wdata : r_limit;
        n_used      = r_used;
        n_total     = r_total;
        n_last_lend = r_last_lend;
        n_last_pend = r_last_pend;
        n_last_len  = r_last_len;
        n_off       = r_off;
        n_cnt       = r_cnt;
        n_offend    = r_offend;
        n_inject    = 1'b0;
        n_hit       = r_hit;
        n_cov       = r_cov;
        n_lo        = r_lo;
        n_phys      = r_phys;
        n_len       = r_len;
        n_delta     = r_delta;
        n_run       = r_run;
        n_done      = 1'b0;
        n_status    = r_status;
        n_fo        = r_fo;
        n_fs        = r_fs;
        n_fc        = r_fc;
        o_wr        = '0;
        o_wr_idx    = IW'(r_used);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = STAT_OK;
                    n_fo     = '0;
                    n_fs     = '0;
                    n_fc     = '0;
                    case (i_kind)
                        KIND_CLEAR: begin
                            n_used  = '0;
                            n_total = '0;
                            n_done  = 1'b1;
                        end
                        KIND_APPEND: begin
                            n_done = 1'b1;
                            if (i_block_count == '0) begin
                                n_total = i_logical_offset;
                            end else if (merge) begin
                                // Extend the last entry in place.
                                o_wr.we_len = 1'b1;
                                o_wr.len    = r_last_len + i_block_count;
                                o_wr_idx    = IW'(r_used - UW'(1));
                                n_last_len  = r_last_len + i_block_count;
                                n_last_lend = r_last_lend + i_block_count;
                                n_last_pend = r_last_pend + i_block_count;
                                n_total     = new_end;
                            end else if (full) begin
                                n_status = STAT_FULL;
                            end else begin
                                o_wr.we_new = 1'b1;
                                o_wr.lo     = i_logical_offset;
                                o_wr.phys   = i_physical_sector;
                                o_wr.len    = i_block_count;
                                n_last_len  = i_block_count;
                                n_last_lend = new_end;
                                n_last_pend = i_physical_sector + i_block_count;
                                n_used      = r_used + UW'(1);
                                n_total     = new_end;
                            end
                        end
                        KIND_LOOKUP: begin
                            n_off    = i_logical_offset;
                            n_cnt    = i_block_count;
                            n_offend = new_end;
                            n_inject = 1'b1;
                            n_state  = S_SCAN;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Wait for the token to leave the last cell.
                if (i_tail.valid) begin
                    n_hit   = i_tail.hit;
                    n_cov   = i_tail.cov;
                    n_lo    = i_tail.lo;
                    n_phys  = i_tail.phys;
                    n_len   = i_tail.len;
                    n_state = S_FIN1;
                end
            end
            S_FIN1: begin
                n_delta = r_cov ? r_off - r_lo : r_lo - r_off;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                n_run   = r_cov ? r_len - r_delta : r_cnt - r_delta;
                n_state = S_FIN3;
            end
            S_FIN3: begin
                n_done   = 1'b1;
                n_status = STAT_OK;
                n_fs     = '0;
                n_fc     = '0;
                if (r_hit && r_cov) begin
                    n_fo = r_off;
                    n_fs = r_phys + r_delta;
                    n_fc = (r_run > r_cnt) ? r_cnt : r_run;
                end else if (r_hit) begin
                    n_fo = r_lo;
                    n_fs = r_phys;
                    n_fc = (r_len > r_run) ? r_run : r_len;
                end else if (r_offend > r_total) begin
                    n_status = STAT_RANGE;
                    n_fo     = '0;
                end else begin
                    // Sparse tail past the last extent.
                    n_fo = r_offend;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= LIMIT_RESET;
            r_used   <= '0;
            r_total  <= '0;
            r_inject <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_limit  <= n_limit;
            r_used   <= n_used;
            r_total  <= n_total;
            r_inject <= n_inject;
            r_done   <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_last_lend <= n_last_lend;
        r_last_pend <= n_last_pend;
        r_last_len  <= n_last_len;
        r_off       <= n_off;
        r_cnt       <= n_cnt;
        r_offend    <= n_offend;
        r_hit       <= n_hit;
        r_cov       <= n_cov;
        r_lo        <= n_lo;
        r_phys      <= n_phys;
        r_len       <= n_len;
        r_delta     <= n_delta;
        r_run       <= n_run;
        r_status    <= n_status;
        r_fo        <= n_fo;
        r_fs        <= n_fs;
        r_fc        <= n_fc;
    end

    // Token injected into the first cell in the cycle after a lookup beat.
    always_comb begin
        o_tok       = '0;
        o_tok.valid = r_inject;
    end

    assign o_left         = r_used;
    assign o_off          = r_off;
    assign o_offend       = r_offend;
    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_found_offset = r_fo;
    assign o_found_sector = r_fs;
    assign o_found_count  = r_fc;
    assign o_entries_used = LIMIT_W'(r_used);
    assign o_mapped_size  = r_total;

endmodule

### hw/rtl/extent_map_append_lookup_top.sv
// Top level of the extent map: controller and the chain of table cells.
//
// Clear, append and unused-kind beats are taken without raising busy, and
// their result strobes on o_done in the next cycle. A lookup raises busy
// while its token walks the chain of cells, one cell per cycle, whatever
// the number of entries in use, and while S_FIN1, S_FIN2 and S_FIN3 form
// the run; the result strobes in the cycle busy falls. The result is shown
// for one cycle only and cannot be held off, so it must be captured then.
// The fragment limit may be written only while busy is low and no result is
// pending.
module extent_map_append_lookup_top #(
    parameter int MAX_ENTRIES = emal_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [emal_pkg::KIND_W-1:0]  i_kind,
    input  logic [emal_pkg::DATA_W-1:0]  i_logical_offset,
    input  logic [emal_pkg::DATA_W-1:0]  i_physical_sector,
    input  logic [emal_pkg::DATA_W-1:0]  i_block_count,
    input  logic                         i_cfg_we,
    input  logic [emal_pkg::LIMIT_W-1:0] i_cfg_wdata,
    output logic                         o_done,
    output logic [emal_pkg::STAT_W-1:0]  o_status,
    output logic [emal_pkg::DATA_W-1:0]  o_found_offset,
    output logic [emal_pkg::DATA_W-1:0]  o_found_sector,
    output logic [emal_pkg::DATA_W-1:0]  o_found_count,
    output logic [emal_pkg::LIMIT_W-1:0] o_entries_used,
    output logic [emal_pkg::DATA_W-1:0]  o_mapped_size
);
    import emal_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int UW = $clog2(MAX_ENTRIES + 1);

    t_wr               wr;
    logic [IW-1:0]     wr_idx;
    logic [DATA_W-1:0] off;
    logic [DATA_W-1:0] offend;
    t_tok              tok  [0:MAX_ENTRIES];
    logic [UW-1:0]     left [0:MAX_ENTRIES];

    emal_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IW          (IW),
        .UW          (UW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_logical_offset  (i_logical_offset),
        .i_physical_sector (i_physical_sector),
        .i_block_count     (i_block_count),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_wr              (wr),
        .o_wr_idx          (wr_idx),
        .o_off             (off),
        .o_offend          (offend),
        .o_tok             (tok[0]),
        .o_left            (left[0]),
        .i_tail            (tok[MAX_ENTRIES]),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_found_offset    (o_found_offset),
        .o_found_sector    (o_found_sector),
        .o_found_count     (o_found_count),
        .o_entries_used    (o_entries_used),
        .o_mapped_size     (o_mapped_size)
    );

    // Chain of cells, entry i in cell i; the token moves one cell per cycle.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        emal_cell #(
            .IDX (g),
            .IW  (IW),
            .UW  (UW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr     (wr),
            .i_wr_idx (wr_idx),
            .i_off    (off),
            .i_offend (offend),
            .i_tok    (tok[g]),
            .i_left   (left[g]),
            .o_tok    (tok[g+1]),
            .o_left   (left[g+1])
        );
    end

endmodule

### hw/rtl/emal_checker.sv
// Port-level checks for the extent map top level, and their bind.
module emal_checker #(
    parameter int MAX_ENTRIES = emal_pkg::MAX_ENTRIES_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [emal_pkg::KIND_W-1:0]  i_kind,
    input logic                         o_done,
    input logic [emal_pkg::STAT_W-1:0]  o_status,
    input logic [emal_pkg::DATA_W-1:0]  o_found_offset,
    input logic [emal_pkg::DATA_W-1:0]  o_found_sector,
    input logic [emal_pkg::DATA_W-1:0]  o_found_count,
    input logic [emal_pkg::LIMIT_W-1:0] o_entries_used,
    input logic [emal_pkg::DATA_W-1:0]  o_mapped_size
);
    import emal_pkg::*;

    // A beat that is not a lookup gives its result in the next cycle.
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_kind != KIND_LOOKUP) |=> o_done && !busy)
        else $error("non-lookup beat gave no result in the next cycle");

    // A lookup beat holds the block busy.
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_kind == KIND_LOOKUP) |=> busy && !o_done)
        else $error("lookup beat did not hold busy");

    // A clear empties the table and the mapped size.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_kind == KIND_CLEAR)
        |=> (o_entries_used == '0) && (o_mapped_size == '0))
        else $error("clear left entries or size behind");

    // An error result carries no run.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != STAT_OK)
        |-> (o_found_offset == '0) && (o_found_sector == '0) && (o_found_count == '0))
        else $error("error result carried run fields");

    // The table never holds more entries than its depth.
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_entries_used) <= 32'(MAX_ENTRIES)))
        else $error("entries in use exceed table depth");

endmodule

bind extent_map_append_lookup_top emal_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_emal_checker (.*);
